[hw/rtl/bcdo_pkg.sv]
// Package with the shared types, constants and calendar functions of the day offset block.
`timescale 1ns / 1ps

package bcdo_pkg;

   localparam int ACC_W = 34;

   localparam logic [11:0] FIRST_YEAR      = 12'd1900;
   localparam logic [11:0] LAST_YEAR       = 12'd2099;
   localparam logic [11:0] CENTURY_2100    = 12'd2100;
   localparam logic [3:0]  FIRST_MONTH     = 4'd1;
   localparam logic [3:0]  LAST_MONTH      = 4'd12;
   localparam logic [16:0] SPAN_DAYS       = 17'd73049;
   localparam logic [8:0]  DAYS_COMMON     = 9'd365;
   localparam logic [8:0]  DAYS_LEAP       = 9'd366;
   localparam logic [3:0]  MOD_TOP_SHIFT   = 4'd15;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type       op;
      logic [ACC_W-1:0] a;
      logic [ACC_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [ACC_W-1:0] res;
      logic             neg;
   } alu_rsp_type;

   // Exact for every year the block can reach: 2000 is the only century year
   // in the window that is a leap year.
   function automatic logic is_leap(input logic [11:0] y);
      return (y[1:0] == 2'b00) && (y != FIRST_YEAR) && (y != CENTURY_2100);
   endfunction

   function automatic logic [8:0] year_days(input logic [11:0] y);
      return is_leap(y) ? DAYS_LEAP : DAYS_COMMON;
   endfunction

   function automatic logic [4:0] month_days(input logic [11:0] y, input logic [3:0] m);
      logic [4:0] len;
      case (m)
         4'd2: begin
            len = is_leap(y) ? 5'd29 : 5'd28;
         end
         4'd4, 4'd6, 4'd9, 4'd11: begin
            len = 5'd30;
         end
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: begin
            len = 5'd31;
         end
         default: begin
            len = 5'd0;
         end
      endcase
      return len;
   endfunction

endpackage

[hw/rtl/bcdo_alu.sv]
// Shared add and subtract unit used by all the arithmetic steps of the sequencer.
`timescale 1ns / 1ps

module bcdo_alu (
   input  bcdo_pkg::alu_req_type req,
   output bcdo_pkg::alu_rsp_type rsp
);
   import bcdo_pkg::*;

   logic [ACC_W-1:0] operand_b;

   always_comb begin
      operand_b = (req.op == ALU_SUB) ? ~req.b : req.b;
      rsp.res   = req.a + operand_b + {{(ACC_W-1){1'b0}}, (req.op == ALU_SUB)};
      rsp.neg   = rsp.res[ACC_W-1];
   end

endmodule

[hw/rtl/bounded_calendar_day_offset_top.sv]
// Top level: date check, sequencer around the shared unit, and result register.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | start_year, start_month, start_day, day_offset
//   rsp     | out       | rsp_valid/rsp_stall | result_year/month/day, start/result_serial,
//           |           |                     | start_replaced
//
// The time from taking an item to rsp_valid grows with the checked start year and month and
// with the result year and month, since the year and month walks go through the single adder.
// The sequencer is back in idle, and can take the next item, from the cycle in which rsp_valid
// rises.
// Reset is synchronous and active high; it clears the sequencer and the result valid.
// A new item is taken only while the sequencer is idle; a result waiting under rsp_stall
// does not hold up the work on the next item, only its final hand-over.
`timescale 1ns / 1ps

module bounded_calendar_day_offset_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [11:0]        req_start_year,
   input  logic [3:0]         req_start_month,
   input  logic [4:0]         req_start_day,
   input  logic signed [31:0] req_day_offset,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [11:0]        rsp_result_year,
   output logic [3:0]         rsp_result_month,
   output logic [4:0]         rsp_result_day,
   output logic [16:0]        rsp_start_serial,
   output logic [16:0]        rsp_result_serial,
   output logic               rsp_start_replaced
);
   import bcdo_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SYEAR,
      S_SMON,
      S_SDAY,
      S_SUM,
      S_ABS,
      S_MOD,
      S_FIX,
      S_RYEAR,
      S_RMON,
      S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [11:0]      yr_ff, yr_in;
   logic [3:0]       mon_ff, mon_in;
   logic [4:0]       day_ff, day_in;
   logic [31:0]      off_ff, off_in;
   logic             repl_ff, repl_in;
   logic [11:0]      cnt_ff, cnt_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [16:0]      sserial_ff, sserial_in;
   logic [16:0]      rserial_ff, rserial_in;
   logic             neg_ff, neg_in;
   logic [3:0]       shift_ff, shift_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [11:0]      rsp_year_ff, rsp_year_in;
   logic [3:0]       rsp_month_ff, rsp_month_in;
   logic [4:0]       rsp_day_ff, rsp_day_in;
   logic [16:0]      rsp_sserial_ff, rsp_sserial_in;
   logic [16:0]      rsp_rserial_ff, rsp_rserial_in;
   logic             rsp_repl_ff, rsp_repl_in;

   alu_req_type      alu_req;
   alu_rsp_type      alu_rsp;
   logic             start_ok;
   logic             req_take;
   logic             out_free;
   logic [ACC_W-1:0] span_ext;

   bcdo_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   assign span_ext  = {{(ACC_W-17){1'b0}}, SPAN_DAYS};
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign start_ok = (req_start_year >= FIRST_YEAR) && (req_start_year <= LAST_YEAR) &&
                     (req_start_month >= FIRST_MONTH) && (req_start_month <= LAST_MONTH) &&
                     (req_start_day != 5'd0) &&
                     (req_start_day <= month_days(req_start_year, req_start_month));

   always_comb begin
      alu_req.op = ALU_ADD;
      alu_req.a  = acc_ff;
      alu_req.b  = '0;
      case (state_ff)
         S_SYEAR: begin
            alu_req.b = {{(ACC_W-9){1'b0}}, year_days(cnt_ff)};
         end
         S_SMON: begin
            alu_req.b = {{(ACC_W-5){1'b0}}, month_days(yr_ff, cnt_ff[3:0])};
         end
         S_SDAY: begin
            alu_req.b = {{(ACC_W-5){1'b0}}, day_ff - 5'd1};
         end
         S_SUM: begin
            alu_req.b = {{(ACC_W-32){off_ff[31]}}, off_ff};
         end
         S_ABS: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = '0;
            alu_req.b  = acc_ff;
         end
         S_MOD: begin
            alu_req.op = ALU_SUB;
            alu_req.b  = span_ext << shift_ff;
         end
         S_FIX: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = span_ext;
            alu_req.b  = acc_ff;
         end
         S_RYEAR: begin
            alu_req.op = ALU_SUB;
            alu_req.b  = {{(ACC_W-9){1'b0}}, year_days(yr_ff)};
         end
         S_RMON: begin
            alu_req.op = ALU_SUB;
            alu_req.b  = {{(ACC_W-5){1'b0}}, month_days(yr_ff, mon_ff)};
         end
         default: begin
            alu_req.op = ALU_ADD;
         end
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      yr_in          = yr_ff;
      mon_in         = mon_ff;
      day_in         = day_ff;
      off_in         = off_ff;
      repl_in        = repl_ff;
      cnt_in         = cnt_ff;
      acc_in         = acc_ff;
      sserial_in     = sserial_ff;
      rserial_in     = rserial_ff;
      neg_in         = neg_ff;
      shift_in       = shift_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_year_in    = rsp_year_ff;
      rsp_month_in   = rsp_month_ff;
      rsp_day_in     = rsp_day_ff;
      rsp_sserial_in = rsp_sserial_ff;
      rsp_rserial_in = rsp_rserial_ff;
      rsp_repl_in    = rsp_repl_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               yr_in    = start_ok ? req_start_year : FIRST_YEAR;
               mon_in   = start_ok ? req_start_month : FIRST_MONTH;
               day_in   = start_ok ? req_start_day : 5'd1;
               repl_in  = !start_ok;
               off_in   = req_day_offset;
               cnt_in   = FIRST_YEAR;
               acc_in   = '0;
               state_in = S_SYEAR;
            end
         end
         S_SYEAR: begin
            if (cnt_ff == yr_ff) begin
               cnt_in   = {8'd0, FIRST_MONTH};
               state_in = S_SMON;
            end else begin
               acc_in = alu_rsp.res;
               cnt_in = cnt_ff + 12'd1;
            end
         end
         S_SMON: begin
            if (cnt_ff[3:0] == mon_ff) begin
               state_in = S_SDAY;
            end else begin
               acc_in = alu_rsp.res;
               cnt_in = cnt_ff + 12'd1;
            end
         end
         S_SDAY: begin
            acc_in   = alu_rsp.res;
            state_in = S_SUM;
         end
         S_SUM: begin
            sserial_in = acc_ff[16:0];
            acc_in     = alu_rsp.res;
            state_in   = S_ABS;
         end
         S_ABS: begin
            // Reduce the magnitude and fold the sign back in at the end.
            neg_in   = acc_ff[ACC_W-1];
            acc_in   = acc_ff[ACC_W-1] ? alu_rsp.res : acc_ff;
            shift_in = MOD_TOP_SHIFT;
            state_in = S_MOD;
         end
         S_MOD: begin
            if (!alu_rsp.neg) begin
               acc_in = alu_rsp.res;
            end
            shift_in = shift_ff - 4'd1;
            if (shift_ff == 4'd0) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            if (neg_ff && (acc_ff != '0)) begin
               acc_in     = alu_rsp.res;
               rserial_in = alu_rsp.res[16:0];
            end else begin
               rserial_in = acc_ff[16:0];
            end
            yr_in    = FIRST_YEAR;
            state_in = S_RYEAR;
         end
         S_RYEAR: begin
            if (!alu_rsp.neg && (yr_ff < LAST_YEAR)) begin
               acc_in = alu_rsp.res;
               yr_in  = yr_ff + 12'd1;
            end else begin
               mon_in   = FIRST_MONTH;
               state_in = S_RMON;
            end
         end
         S_RMON: begin
            if (!alu_rsp.neg && (mon_ff < LAST_MONTH)) begin
               acc_in = alu_rsp.res;
               mon_in = mon_ff + 4'd1;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_year_in    = yr_ff;
               rsp_month_in   = mon_ff;
               rsp_day_in     = acc_ff[4:0] + 5'd1;
               rsp_sserial_in = sserial_ff;
               rsp_rserial_in = rserial_ff;
               rsp_repl_in    = repl_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      yr_ff          <= yr_in;
      mon_ff         <= mon_in;
      day_ff         <= day_in;
      off_ff         <= off_in;
      repl_ff        <= repl_in;
      cnt_ff         <= cnt_in;
      acc_ff         <= acc_in;
      sserial_ff     <= sserial_in;
      rserial_ff     <= rserial_in;
      neg_ff         <= neg_in;
      shift_ff       <= shift_in;
      rsp_year_ff    <= rsp_year_in;
      rsp_month_ff   <= rsp_month_in;
      rsp_day_ff     <= rsp_day_in;
      rsp_sserial_ff <= rsp_sserial_in;
      rsp_rserial_ff <= rsp_rserial_in;
      rsp_repl_ff    <= rsp_repl_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_year    = rsp_year_ff;
   assign rsp_result_month   = rsp_month_ff;
   assign rsp_result_day     = rsp_day_ff;
   assign rsp_start_serial   = rsp_sserial_ff;
   assign rsp_result_serial  = rsp_rserial_ff;
   assign rsp_start_replaced = rsp_repl_ff;

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the bounded calendar day offset block.
`timescale 1ns / 1ps

module tb_top;
   import bcdo_pkg::*;

   localparam int YEAR_LO     = int'(FIRST_YEAR);
   localparam int YEAR_HI     = int'(LAST_YEAR);
   localparam int MONTH_LO    = int'(FIRST_MONTH);
   localparam int MONTH_HI    = int'(LAST_MONTH);
   localparam int SPAN        = int'(SPAN_DAYS);
   localparam int RANDOM_ITEMS = 450;
   localparam int DRAIN_CYCLES = 500;
   localparam int CYCLE_LIMIT  = 1000000;

   typedef struct {
      logic [11:0]        year;
      logic [3:0]         month;
      logic [4:0]         day;
      logic signed [31:0] offset;
   } date_item_type;

   typedef struct {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [16:0] start_serial;
      logic [16:0] result_serial;
      logic        replaced;
   } shift_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [11:0]        req_start_year = '0;
   logic [3:0]         req_start_month = '0;
   logic [4:0]         req_start_day = '0;
   logic signed [31:0] req_day_offset = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [11:0]        rsp_result_year;
   logic [3:0]         rsp_result_month;
   logic [4:0]         rsp_result_day;
   logic [16:0]        rsp_start_serial;
   logic [16:0]        rsp_result_serial;
   logic               rsp_start_replaced;

   date_item_type    pending_dates[$];
   shift_result_type expected_shifts[$];
   int               total_dates;
   int               dates_taken;
   int               mismatches;
   int               send_gap;
   int               take_gap;
   bit               send_quiet;
   bit               take_quiet;
   int               cycle_count;
   date_item_type    next_date;
   shift_result_type want;

   bounded_calendar_day_offset_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_start_year     (req_start_year),
      .req_start_month    (req_start_month),
      .req_start_day      (req_start_day),
      .req_day_offset     (req_day_offset),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_year    (rsp_result_year),
      .rsp_result_month   (rsp_result_month),
      .rsp_result_day     (rsp_result_day),
      .rsp_start_serial   (rsp_start_serial),
      .rsp_result_serial  (rsp_result_serial),
      .rsp_start_replaced (rsp_start_replaced)
   );

   function automatic bit leap_year(input int y);
      return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
   endfunction

   function automatic int days_of_year(input int y);
      return leap_year(y) ? 366 : 365;
   endfunction

   function automatic int days_of_month(input int y, input int m);
      int len;
      case (m)
         2: begin
            len = leap_year(y) ? 29 : 28;
         end
         4, 6, 9, 11: begin
            len = 30;
         end
         1, 3, 5, 7, 8, 10, 12: begin
            len = 31;
         end
         default: begin
            len = 0;
         end
      endcase
      return len;
   endfunction

   // Expected result of one item: validate, take the serial, shift, wrap, convert back.
   function automatic shift_result_type shift_date(input date_item_type item);
      shift_result_type res;
      int               y;
      int               m;
      int               d;
      int               serial;
      int               rem;
      longint           total;
      y = item.year;
      m = item.month;
      d = item.day;
      res.replaced = 1'b0;
      if (y < YEAR_LO || y > YEAR_HI || m < MONTH_LO || m > MONTH_HI || d < 1 ||
          d > days_of_month(y, m)) begin
         y = YEAR_LO;
         m = MONTH_LO;
         d = 1;
         res.replaced = 1'b1;
      end
      serial = 0;
      for (int k = YEAR_LO; k < y; k++) begin
         serial += days_of_year(k);
      end
      for (int k = MONTH_LO; k < m; k++) begin
         serial += days_of_month(y, k);
      end
      serial += d - 1;
      // The sum is formed in 64 bits so that no offset can overflow it.
      total = longint'(serial) + longint'(item.offset);
      rem = int'(total % longint'(SPAN));
      if (rem < 0) begin
         rem += SPAN;
      end
      res.start_serial = serial[16:0];
      res.result_serial = rem[16:0];
      y = YEAR_LO;
      while (y < YEAR_HI && rem >= days_of_year(y)) begin
         rem -= days_of_year(y);
         y++;
      end
      m = MONTH_LO;
      while (m < MONTH_HI && rem >= days_of_month(y, m)) begin
         rem -= days_of_month(y, m);
         m++;
      end
      res.year = y[11:0];
      res.month = m[3:0];
      res.day = 5'(rem + 1);
      return res;
   endfunction

   task automatic add_date(input int y, input int m, input int d, input int off);
      date_item_type item;
      item.year = y[11:0];
      item.month = m[3:0];
      item.day = d[4:0];
      item.offset = off;
      pending_dates.push_back(item);
   endtask

   // Mostly well-formed dates; the rest are near misses and raw noise.
   function automatic date_item_type random_date();
      date_item_type    item;
      shift_result_type base;
      int               kind;
      int               pick;
      int               len;
      int               multiple;
      kind = $urandom_range(0, 99);
      item.year = 12'($urandom_range(YEAR_LO, YEAR_HI));
      item.month = 4'($urandom_range(MONTH_LO, MONTH_HI));
      len = days_of_month(item.year, item.month);
      item.day = 5'($urandom_range(1, len));
      if (kind >= 85) begin
         item.year = 12'($urandom_range(0, 4095));
         item.month = 4'($urandom_range(0, 15));
         item.day = 5'($urandom_range(0, 31));
      end else if (kind >= 70) begin
         pick = $urandom_range(0, 5);
         case (pick)
            0: item.day = 5'(len + 1);
            1: item.day = 5'd0;
            2: item.month = 4'($urandom_range(0, 1) ? 0 : $urandom_range(13, 15));
            3: item.year = $urandom_range(0, 1) ? 12'(YEAR_LO - 1) : 12'(YEAR_HI + 1);
            4: begin
               item.month = 4'd2;
               item.day = 5'd29;
            end
            default: item.day = 5'd31;
         endcase
      end
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1, 2: item.offset = $urandom_range(0, 800) - 400;
         3, 4: item.offset = $urandom_range(0, 2 * SPAN) - SPAN;
         5: begin
            // Land the sum exactly on a multiple of the span, either sign.
            multiple = int'($urandom_range(0, 58000)) - 29000;
            item.offset = 0;
            base = shift_date(item);
            item.offset = multiple * SPAN - int'(base.start_serial);
         end
         6, 7, 8: item.offset = $urandom;
         default: begin
            case ($urandom_range(0, 3))
               0: item.offset = 32'h8000_0000;
               1: item.offset = 32'h7fff_ffff;
               2: item.offset = 0;
               default: item.offset = -1;
            endcase
         end
      endcase
      return item;
   endfunction

   task automatic check_field(input string name, input longint exp_val, input longint got);
      if (exp_val != got) begin
         $error("%s: expected %0d, got %0d", name, exp_val, got);
         mismatches++;
      end
   endtask

   initial begin
      forever #2 clock = ~clock;
   end

   // Driver: one item held until taken, then a drawn gap before the next.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else if (!(req_valid && req_stall)) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_dates.size() > 0) begin
            next_date = pending_dates.pop_front();
            req_valid <= 1'b1;
            req_start_year <= next_date.year;
            req_start_month <= next_date.month;
            req_start_day <= next_date.day;
            req_day_offset <= next_date.offset;
            if ($urandom_range(0, 29) == 0) begin
               send_quiet = !send_quiet;
            end
            send_gap = send_quiet ? 0 : $urandom_range(0, 12);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side: after each taken result, stall the next one for a drawn number of cycles.
   always @(posedge clock) begin
      if (reset) begin
         take_gap = 0;
      end else if (rsp_valid && !rsp_stall) begin
         if ($urandom_range(0, 29) == 0) begin
            take_quiet = !take_quiet;
         end
         take_gap = take_quiet ? 0 : $urandom_range(0, 12);
      end else if (rsp_valid && take_gap > 0) begin
         take_gap--;
      end
      rsp_stall <= (take_gap > 0);
   end

   // Monitor: predicts each item taken and checks each result handed over.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_shifts.push_back(shift_date('{req_start_year, req_start_month,
                                                   req_start_day, req_day_offset}));
            dates_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_shifts.size() == 0) begin
               $error("result with no item outstanding: %0d-%0d-%0d", rsp_result_year,
                      rsp_result_month, rsp_result_day);
               mismatches++;
            end else begin
               want = expected_shifts.pop_front();
               check_field("result_year", want.year, rsp_result_year);
               check_field("result_month", want.month, rsp_result_month);
               check_field("result_day", want.day, rsp_result_day);
               check_field("start_serial", want.start_serial, rsp_start_serial);
               check_field("result_serial", want.result_serial, rsp_result_serial);
               check_field("start_replaced", want.replaced, rsp_start_replaced);
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("bounded_calendar_day_offset_top regression: fail");
      $finish;
   end

   initial begin
      add_date(1900, 1, 1, 0);
      add_date(2099, 12, 31, 0);
      add_date(2099, 12, 31, 1);
      add_date(1900, 1, 1, -1);
      add_date(1900, 1, 1, -SPAN);
      add_date(1900, 1, 1, -2 * SPAN);
      add_date(1900, 1, 1, SPAN - 1);
      add_date(2099, 12, 31, -(SPAN - 1));
      add_date(2000, 12, 31, SPAN);
      add_date(2000, 2, 29, 0);
      add_date(1900, 2, 29, 0);
      add_date(2099, 2, 29, 3);
      add_date(2023, 2, 29, 0);
      add_date(2096, 2, 29, 1);
      add_date(1904, 12, 31, 1);
      add_date(2100, 1, 1, 5);
      add_date(1899, 12, 31, 5);
      add_date(0, 0, 0, 0);
      add_date(4095, 15, 31, 32'h7fff_ffff);
      add_date(2024, 2, 29, 32'h8000_0000);
      add_date(2099, 12, 31, 32'h7fff_ffff);
      add_date(2021, 4, 31, 0);
      add_date(2021, 13, 1, 0);
      add_date(2021, 6, 0, 0);
      repeat (RANDOM_ITEMS) begin
         pending_dates.push_back(random_date());
      end
      total_dates = pending_dates.size();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      do begin
         @(negedge clock);
      end while (dates_taken < total_dates || expected_shifts.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && expected_shifts.size() == 0) begin
         $display("bounded_calendar_day_offset_top regression: pass");
      end else begin
         $display("bounded_calendar_day_offset_top regression: fail");
      end
      $finish;
   end

endmodule
